// ===== rtl/sem_pkg.sv =====
// ----------------------------------------------------------------------------
// sem_pkg
// Shared widths, register indexes, queue items and the square root step for
// the Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int PIX_W       = 8;
    localparam int MAG_W       = 11;
    localparam int LVL_W       = 8;
    localparam int COL_W       = 11;
    localparam int ROW_W       = 16;
    localparam int CFG_W_W     = 12;
    localparam int CFG_H_W     = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int GRAD_W      = 11;
    localparam int SQ_W        = 20;
    localparam int SUM_W       = 21;
    localparam int REM_W       = 22;
    localparam int ROOT_STEPS  = 11;
    localparam int MID_DEPTH   = 8;
    localparam int OUT_DEPTH   = 16;
    localparam int FIRST_INNER = 2;
    localparam int LVL_MAX     = 255;
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [COL_W-1:0] center_col;
        logic [ROW_W-1:0] center_row;
        logic             frame_last;
    } t_tag;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        t_tag             tag;
    } t_mid_item;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic [LVL_W-1:0] edge_level;
        t_tag             tag;
    } t_out_item;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [REM_W-1:0] root;
    } t_root;

    // One digit of the restoring square root; step k tests bit 4^(ROOT_STEPS-1-k).
    function automatic t_root root_step(t_root s, int k);
        logic [REM_W-1:0] bit_v;
        logic [REM_W-1:0] trial;
        t_root            o;
        bit_v = REM_W'(1) << (2 * (ROOT_STEPS - 1 - k));
        trial = s.root + bit_v;
        if (s.rem >= trial) begin
            o.rem  = s.rem - trial;
            o.root = (s.root >> 1) + bit_v;
        end else begin
            o.rem  = s.rem;
            o.root = s.root >> 1;
        end
        return o;
    endfunction

endpackage

// ===== rtl/sem_fifo.sv =====
// ----------------------------------------------------------------------------
// sem_fifo
// Register based first-in first-out queue; the writer keeps it from
// overflowing by credit, the reader pops only while it is not empty.
// ----------------------------------------------------------------------------
module sem_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CNTW-1:0]  r_count;
    logic             pop_ok;

    assign o_empty = (r_count == '0);
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (i_push && !pop_ok) begin
                r_count <= r_count + CNTW'(1);
            end else if (!i_push && pop_ok) begin
                r_count <= r_count - CNTW'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !pop_ok) |-> (r_count < CNTW'(DEPTH)))
        else $error("queue written while full");
`endif

endmodule

// ===== rtl/sem_front.sv =====
// ----------------------------------------------------------------------------
// sem_front
// Raster position, line store, 3x3 window, Sobel gradients and their squares.
// Classifies each pixel as interior result or border and issues results to
// the middle queue under credit.
// ----------------------------------------------------------------------------
module sem_front #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [sem_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_push,
    output logic                              o_full,
    input  logic [sem_pkg::PIX_W-1:0]         i_pixel,
    input  logic                              i_mid_pop,
    output logic                              o_mid_push,
    output sem_pkg::t_mid_item                o_mid_item
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = (CW + 1 > sem_pkg::CFG_W_W) ? CW + 1 : sem_pkg::CFG_W_W;
    localparam int XW    = (CW > sem_pkg::COL_W) ? CW : sem_pkg::COL_W;
    localparam int UW    = $clog2(sem_pkg::MID_DEPTH + 1);
    localparam int RST_W = (sem_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH
                                                               : sem_pkg::RESET_WIDTH;
    localparam int PW    = sem_pkg::PIX_W;
    localparam int GW    = sem_pkg::GRAD_W;
    localparam int RW    = sem_pkg::ROW_W;

    logic [CW-1:0]      r_col_last;
    logic [RW-1:0]      r_row_last;
    logic [CW-1:0]      r_col;
    logic [RW-1:0]      r_row;
    logic [UW-1:0]      r_used;
    logic [UW-1:0]      n_used;

    logic [WW-1:0]      cfg_w;
    logic [CW-1:0]      n_col_last;
    logic [RW-1:0]      n_row_last;

    logic               accept;
    logic               emit;
    logic               col_end;
    logic               row_end;

    logic [2*PW-1:0]    mem [MAX_WIDTH];
    logic [2*PW-1:0]    r_rd;

    logic               r_a_valid;
    logic               r_a_emit;
    logic [PW-1:0]      r_a_pix;
    logic [CW-1:0]      r_a_addr;
    sem_pkg::t_tag      r_a_tag;

    logic               r_b_emit;
    logic signed [GW-1:0] r_b_gx;
    logic signed [GW-1:0] r_b_gy;
    sem_pkg::t_tag      r_b_tag;

    logic               r_c_emit;
    logic [sem_pkg::SQ_W-1:0] r_c_sqx;
    logic [sem_pkg::SQ_W-1:0] r_c_sqy;
    sem_pkg::t_tag      r_c_tag;

    logic [PW-1:0]      r_wl_t, r_wl_m, r_wl_b;
    logic [PW-1:0]      r_wc_t, r_wc_m, r_wc_b;

    logic signed [GW-1:0] e_lt, e_lm, e_lb, e_ct, e_cb, e_rt, e_rm, e_rb;
    logic signed [GW-1:0] gx;
    logic signed [GW-1:0] gy;
    logic signed [2*GW-1:0] gx_w;
    logic signed [2*GW-1:0] gy_w;
    logic [2*GW-1:0]      sqx_full;
    logic [2*GW-1:0]      sqy_full;

    assign o_full  = (r_used == UW'(sem_pkg::MID_DEPTH));
    assign accept  = i_push && !o_full;
    assign emit    = (r_row >= RW'(sem_pkg::FIRST_INNER)) && (r_col >= CW'(sem_pkg::FIRST_INNER));
    assign col_end = (r_col == r_col_last);
    assign row_end = (r_row == r_row_last);

    // clamp the written width to 1..MAX_WIDTH and the height to at least 1
    assign cfg_w = WW'(i_cfg_data[sem_pkg::CFG_W_W-1:0]);

    always_comb begin
        if (cfg_w == '0) begin
            n_col_last = '0;
        end else if (cfg_w > WW'(MAX_WIDTH)) begin
            n_col_last = CW'(MAX_WIDTH - 1);
        end else begin
            n_col_last = CW'(cfg_w - WW'(1));
        end
        if (i_cfg_data[sem_pkg::CFG_H_W-1:0] == '0) begin
            n_row_last = '0;
        end else begin
            n_row_last = RW'(i_cfg_data[sem_pkg::CFG_H_W-1:0]) - RW'(1);
        end
    end

    always_comb begin
        n_used = r_used;
        if ((accept && emit) && !i_mid_pop) begin
            n_used = r_used + UW'(1);
        end else if (!(accept && emit) && i_mid_pop) begin
            n_used = r_used - UW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_last <= CW'(RST_W - 1);
            r_row_last <= RW'(sem_pkg::RESET_HEIGHT - 1);
            r_col      <= '0;
            r_row      <= '0;
            r_used     <= '0;
            r_a_valid  <= 1'b0;
            r_a_emit   <= 1'b0;
            r_b_emit   <= 1'b0;
            r_c_emit   <= 1'b0;
        end else begin
            r_used    <= n_used;
            r_a_valid <= accept;
            r_a_emit  <= accept && emit;
            r_b_emit  <= r_a_emit;
            r_c_emit  <= r_b_emit;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    sem_pkg::REG_WIDTH: begin
                        r_col_last <= n_col_last;
                    end
                    sem_pkg::REG_HEIGHT: begin
                        r_row_last <= n_row_last;
                    end
                    default: begin
                    end
                endcase
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                if (col_end) begin
                    r_col <= '0;
                    r_row <= row_end ? '0 : r_row + RW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    // line store: upper byte is the row two above, lower byte the row above
    always_ff @(posedge i_clk) begin
        if (r_a_valid) begin
            mem[r_a_addr] <= {r_rd[PW-1:0], r_a_pix};
        end
        if (accept) begin
            if (r_a_valid && (r_a_addr == r_col)) begin
                r_rd <= {r_rd[PW-1:0], r_a_pix};
            end else begin
                r_rd <= mem[r_col];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_pix                <= i_pixel;
            r_a_addr               <= r_col;
            r_a_tag.center_col     <= sem_pkg::COL_W'(XW'(r_col) - XW'(1));
            r_a_tag.center_row     <= r_row - RW'(1);
            r_a_tag.frame_last     <= col_end && row_end;
        end
        if (r_a_valid) begin
            r_wl_t <= r_wc_t;
            r_wl_m <= r_wc_m;
            r_wl_b <= r_wc_b;
            r_wc_t <= r_rd[2*PW-1:PW];
            r_wc_m <= r_rd[PW-1:0];
            r_wc_b <= r_a_pix;
        end
    end

    assign e_lt = $signed({{(GW - PW){1'b0}}, r_wl_t});
    assign e_lm = $signed({{(GW - PW){1'b0}}, r_wl_m});
    assign e_lb = $signed({{(GW - PW){1'b0}}, r_wl_b});
    assign e_ct = $signed({{(GW - PW){1'b0}}, r_wc_t});
    assign e_cb = $signed({{(GW - PW){1'b0}}, r_wc_b});
    assign e_rt = $signed({{(GW - PW){1'b0}}, r_rd[2*PW-1:PW]});
    assign e_rm = $signed({{(GW - PW){1'b0}}, r_rd[PW-1:0]});
    assign e_rb = $signed({{(GW - PW){1'b0}}, r_a_pix});

    assign gx = (e_rt + (e_rm <<< 1) + e_rb) - (e_lt + (e_lm <<< 1) + e_lb);
    assign gy = (e_lb + (e_cb <<< 1) + e_rb) - (e_lt + (e_ct <<< 1) + e_rt);

    assign gx_w     = r_b_gx;
    assign gy_w     = r_b_gy;
    assign sqx_full = $unsigned(gx_w * gx_w);
    assign sqy_full = $unsigned(gy_w * gy_w);

    always_ff @(posedge i_clk) begin
        r_b_gx  <= gx;
        r_b_gy  <= gy;
        r_b_tag <= r_a_tag;
        r_c_sqx <= sqx_full[sem_pkg::SQ_W-1:0];
        r_c_sqy <= sqy_full[sem_pkg::SQ_W-1:0];
        r_c_tag <= r_b_tag;
    end

    assign o_mid_push     = r_c_emit;
    assign o_mid_item.sum = sem_pkg::SUM_W'(r_c_sqx) + sem_pkg::SUM_W'(r_c_sqy);
    assign o_mid_item.tag = r_c_tag;

`ifndef SYNTHESIS
    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= r_col_last)
        else $error("column position beyond row end");
    a_mid_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(sem_pkg::MID_DEPTH))
        else $error("middle queue credit exceeded");
`endif

endmodule

// ===== rtl/sem_root.sv =====
// ----------------------------------------------------------------------------
// sem_root
// Pipelined integer square root of gx^2 + gy^2, one digit per stage; yields
// the root and a copy saturated to 8 bits into the result queue under credit.
// ----------------------------------------------------------------------------
module sem_root (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_mid_empty,
    input  sem_pkg::t_mid_item i_mid_item,
    output logic               o_mid_pop,
    input  logic               i_out_pop,
    output logic               o_out_push,
    output sem_pkg::t_out_item o_out_item
);

    localparam int NS = sem_pkg::ROOT_STEPS;
    localparam int UW = $clog2(sem_pkg::OUT_DEPTH + 1);

    sem_pkg::t_root  stg_in  [NS];
    sem_pkg::t_root  stg_out [NS];
    sem_pkg::t_root  r_stg   [NS];
    sem_pkg::t_tag   r_tag   [NS];
    logic [NS-1:0]   r_vld;
    logic [UW-1:0]   r_used;
    logic            issue;
    logic [sem_pkg::REM_W-1:0] root;

    assign issue     = !i_mid_empty && (r_used < UW'(sem_pkg::OUT_DEPTH));
    assign o_mid_pop = issue;

    always_comb begin
        stg_in[0].rem  = sem_pkg::REM_W'(i_mid_item.sum);
        stg_in[0].root = '0;
        for (int k = 1; k < NS; k++) begin
            stg_in[k] = r_stg[k-1];
        end
        for (int k = 0; k < NS; k++) begin
            stg_out[k] = sem_pkg::root_step(stg_in[k], k);
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag[0] <= i_mid_item.tag;
        for (int k = 0; k < NS; k++) begin
            r_stg[k] <= stg_out[k];
        end
        for (int k = 1; k < NS; k++) begin
            r_tag[k] <= r_tag[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_used <= '0;
        end else begin
            r_vld <= {r_vld[NS-2:0], issue};
            if (issue && !i_out_pop) begin
                r_used <= r_used + UW'(1);
            end else if (!issue && i_out_pop) begin
                r_used <= r_used - UW'(1);
            end
        end
    end

    assign root                  = r_stg[NS-1].root;
    assign o_out_push            = r_vld[NS-1];
    assign o_out_item.magnitude  = root[sem_pkg::MAG_W-1:0];
    assign o_out_item.edge_level = (root > sem_pkg::REM_W'(sem_pkg::LVL_MAX))
                                   ? sem_pkg::LVL_W'(sem_pkg::LVL_MAX)
                                   : root[sem_pkg::LVL_W-1:0];
    assign o_out_item.tag        = r_tag[NS-1];

`ifndef SYNTHESIS
    a_out_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(sem_pkg::OUT_DEPTH))
        else $error("result queue credit exceeded");
    a_push_follows_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_push |-> r_used != '0)
        else $error("result leaves root pipeline without credit");
`endif

endmodule

// ===== rtl/sobel_edge_magnitude.sv =====
// ----------------------------------------------------------------------------
// sobel_edge_magnitude
// Streaming 3x3 Sobel gradient magnitude over 8-bit grayscale raster frames.
// Pixels are taken at one per clock sustained while full is low; each pixel
// at row r >= 2 and column c >= 2 yields one result for pixel (r-1, c-1)
// carrying floor(sqrt(gx^2 + gy^2)), that value saturated at 255, its position
// and a last-of-frame flag. Border pixels yield nothing. An accepted pixel's
// result passes the line store read, gradient and squaring registers, the
// middle queue and the digit-per-stage square root pipeline, then the result
// queue, before it reaches the ports. The single line store is read and
// written once per accepted pixel at its column, which allows the one pixel
// per clock rate. Writing frame_width (clamped to 1..MAX_WIDTH, index 0) or
// frame_height (at least 1, index 1) restarts the frame at row 0, column 0;
// write only while idle. The line store needs no clearing after reset, since
// the first two rows of a frame refill it before any result reads it.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [sem_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              push,
    output logic                              full,
    input  logic [sem_pkg::PIX_W-1:0]         i_pixel,
    output logic                              empty,
    input  logic                              pop,
    output logic [sem_pkg::MAG_W-1:0]         o_magnitude,
    output logic [sem_pkg::LVL_W-1:0]         o_edge_level,
    output logic [sem_pkg::COL_W-1:0]         o_center_col,
    output logic [sem_pkg::ROW_W-1:0]         o_center_row,
    output logic                              o_frame_last
);

    logic               mid_push;
    logic               mid_pop;
    logic               mid_empty;
    sem_pkg::t_mid_item mid_in;
    sem_pkg::t_mid_item mid_out;
    logic               out_push;
    logic               out_pop;
    sem_pkg::t_out_item out_in;
    sem_pkg::t_out_item out_head;

    assign out_pop = pop && !empty;

    sem_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .o_full      (full),
        .i_pixel     (i_pixel),
        .i_mid_pop   (mid_pop),
        .o_mid_push  (mid_push),
        .o_mid_item  (mid_in)
    );

    sem_fifo #(
        .WIDTH ($bits(sem_pkg::t_mid_item)),
        .DEPTH (sem_pkg::MID_DEPTH)
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (mid_in),
        .i_pop   (mid_pop),
        .o_data  (mid_out),
        .o_empty (mid_empty)
    );

    sem_root u_root (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_empty (mid_empty),
        .i_mid_item  (mid_out),
        .o_mid_pop   (mid_pop),
        .i_out_pop   (out_pop),
        .o_out_push  (out_push),
        .o_out_item  (out_in)
    );

    sem_fifo #(
        .WIDTH ($bits(sem_pkg::t_out_item)),
        .DEPTH (sem_pkg::OUT_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_in),
        .i_pop   (pop),
        .o_data  (out_head),
        .o_empty (empty)
    );

    assign o_magnitude  = out_head.magnitude;
    assign o_edge_level = out_head.edge_level;
    assign o_center_col = out_head.tag.center_col;
    assign o_center_row = out_head.tag.center_row;
    assign o_frame_last = out_head.tag.frame_last;

endmodule
